### rtl/line_codec_8b10b_macros.svh
// ----------------------------------------------------------------------------
// line_codec_8b10b_macros
// assertion macros shared by the 8b/10b codec
// ----------------------------------------------------------------------------
`ifndef LINE_CODEC_8B10B_MACROS_SVH
`define LINE_CODEC_8B10B_MACROS_SVH

// checked property, quiet while reset is asserted
`define LC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked property, also sampled during reset
`define LC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lc8b10b_pkg.sv
// ----------------------------------------------------------------------------
// lc8b10b_pkg
// code tables and shared types for the 8b/10b codec
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lc8b10b_pkg;

	localparam logic [5:0] SIX_RDM [0:31] = '{
		6'h27, 6'h1D, 6'h2D, 6'h31, 6'h35, 6'h29, 6'h19, 6'h38,
		6'h39, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h17,
		6'h1B, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h3A,
		6'h33, 6'h26, 6'h16, 6'h36, 6'h0E, 6'h2E, 6'h1E, 6'h2B
	};

	localparam logic [5:0] SIX_RDP [0:31] = '{
		6'h18, 6'h22, 6'h12, 6'h31, 6'h0A, 6'h29, 6'h19, 6'h07,
		6'h06, 6'h25, 6'h15, 6'h34, 6'h0D, 6'h2C, 6'h1C, 6'h28,
		6'h24, 6'h23, 6'h13, 6'h32, 6'h0B, 6'h2A, 6'h1A, 6'h05,
		6'h0C, 6'h26, 6'h16, 6'h09, 6'h0E, 6'h11, 6'h21, 6'h14
	};

	localparam logic [3:0] FOUR_RDM [0:7] = '{
		4'hB, 4'h9, 4'h5, 4'hC, 4'hD, 4'hA, 4'h6, 4'hE
	};

	localparam logic [3:0] FOUR_RDP [0:7] = '{
		4'h4, 4'h9, 4'h5, 4'h3, 4'h2, 4'hA, 4'h6, 4'h1
	};

	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	typedef struct packed {
		logic [9:0] code;
		logic       rd;
	} enc_res_t;

	typedef struct packed {
		logic [7:0] data;
		logic       err;
	} dec_res_t;

endpackage

### rtl/line_codec_8b10b.sv
// ----------------------------------------------------------------------------
// line_codec_8b10b
// 8b/10b data codec: encode with running disparity, decode with error flag
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  request   req_valid/req_stall   mode, data_byte, code_word
//  result    res_valid/res_stall   code_out, data_out, decode_error,
//                                  disparity_positive
//
// one request per clock while res_stall does not hold the result register; a
// request passes input register, table logic and result register in turn
// the single disparity bit is updated as an encode request moves into the result
// register, so consecutive requests see it in order
// arst_n clears both valid flags and sets the running disparity negative
// res_stall holds the result register and backs up into req_stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "line_codec_8b10b_macros.svh"

module line_codec_8b10b (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic       mode,
	input  logic [7:0] data_byte,
	input  logic [9:0] code_word,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [9:0] code_out,
	output logic [7:0] data_out,
	output logic       decode_error,
	output logic       disparity_positive
);

	logic                   valid_s1;
	logic                   mode_s1;
	logic [7:0]             byte_s1;
	logic [9:0]             word_s1;
	logic                   res_valid_q;
	logic [9:0]             code_q;
	logic [7:0]             data_q;
	logic                   err_q;
	logic                   rdout_q;
	logic                   rd_q;
	logic                   out_free;
	logic                   advance;
	logic                   load_s1;
	lc8b10b_pkg::enc_res_t  enc_res;
	lc8b10b_pkg::dec_res_t  dec_res;

	assign out_free  = !res_valid_q || !res_stall;
	assign advance   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign load_s1   = req_valid && !req_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1 || advance) begin
			valid_s1 <= load_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			word_s1 <= code_word;
		end
	end

	lc8b10b_enc u_enc (
		.rd_in     (rd_q),
		.data_byte (byte_s1),
		.res       (enc_res)
	);

	lc8b10b_dec u_dec (
		.code_word (word_s1),
		.res       (dec_res)
	);

	// running disparity and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			rd_q        <= 1'b0;
		end else begin
			if (out_free) begin
				res_valid_q <= valid_s1;
			end
			if (advance && mode_s1 == lc8b10b_pkg::MODE_ENCODE) begin
				rd_q <= enc_res.rd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (mode_s1 == lc8b10b_pkg::MODE_ENCODE) begin
				code_q  <= enc_res.code;
				data_q  <= 8'd0;
				err_q   <= 1'b0;
				rdout_q <= enc_res.rd;
			end else begin
				code_q  <= 10'd0;
				data_q  <= dec_res.data;
				err_q   <= dec_res.err;
				rdout_q <= rd_q;
			end
		end
	end

	assign res_valid          = res_valid_q;
	assign code_out           = code_q;
	assign data_out           = data_q;
	assign decode_error       = err_q;
	assign disparity_positive = rdout_q;

	`LC_ASSERT(a_err_no_data, res_valid && decode_error |-> data_out == 8'd0, "error with data")
	`LC_ASSERT(a_dec_keeps_rd, advance && mode_s1 == lc8b10b_pkg::MODE_DECODE |=> rd_q == $past(rd_q), "decode moved disparity")
	`LC_ASSERT(a_enc_rd_out, advance && mode_s1 == lc8b10b_pkg::MODE_ENCODE |=> disparity_positive == rd_q, "disparity mismatch")
	`LC_ASSERT_ALWAYS(a_stall_needs_s1, req_stall |-> valid_s1, "stall with empty stage")

endmodule

### rtl/lc8b10b_enc.sv
// ----------------------------------------------------------------------------
// lc8b10b_enc
// data byte to ten-bit symbol, with running disparity update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lc8b10b_enc (
	input  logic                    rd_in,
	input  logic [7:0]              data_byte,
	output lc8b10b_pkg::enc_res_t   res
);

	logic [4:0] lo;
	logic [2:0] hi;
	logic [5:0] s6;
	logic [3:0] s4;
	logic [2:0] ones6;
	logic [2:0] ones4;
	logic       rd_mid;
	logic       rd_end;

	assign lo = data_byte[4:0];
	assign hi = data_byte[7:5];

	always_comb begin
		s6 = rd_in ? lc8b10b_pkg::SIX_RDP[lo] : lc8b10b_pkg::SIX_RDM[lo];
		ones6 = 3'(s6[0]) + 3'(s6[1]) + 3'(s6[2]) + 3'(s6[3]) + 3'(s6[4]) + 3'(s6[5]);
		if (ones6 > 3'd3) begin
			rd_mid = 1'b1;
		end else if (ones6 < 3'd3) begin
			rd_mid = 1'b0;
		end else begin
			rd_mid = rd_in;
		end
		s4 = rd_mid ? lc8b10b_pkg::FOUR_RDP[hi] : lc8b10b_pkg::FOUR_RDM[hi];
		ones4 = 3'(s4[0]) + 3'(s4[1]) + 3'(s4[2]) + 3'(s4[3]);
		if (ones4 > 3'd2) begin
			rd_end = 1'b1;
		end else if (ones4 < 3'd2) begin
			rd_end = 1'b0;
		end else begin
			rd_end = rd_mid;
		end
	end

	assign res.code = {s6, s4};
	assign res.rd   = rd_end;

endmodule

### rtl/lc8b10b_dec.sv
// ----------------------------------------------------------------------------
// lc8b10b_dec
// ten-bit symbol to data byte, either disparity form, invalid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lc8b10b_dec (
	input  logic [9:0]              code_word,
	output lc8b10b_pkg::dec_res_t   res
);

	logic [4:0] v6;
	logic [2:0] v4;
	logic       ok6;
	logic       ok4;

	always_comb begin
		v6  = '0;
		ok6 = 1'b0;
		for (int i = 0; i < 32; i++) begin
			if (!ok6 && (lc8b10b_pkg::SIX_RDM[i] == code_word[9:4] ||
				lc8b10b_pkg::SIX_RDP[i] == code_word[9:4])) begin
				ok6 = 1'b1;
				v6  = 5'(i);
			end
		end
	end

	always_comb begin
		v4  = '0;
		ok4 = 1'b0;
		for (int j = 0; j < 8; j++) begin
			if (!ok4 && (lc8b10b_pkg::FOUR_RDM[j] == code_word[3:0] ||
				lc8b10b_pkg::FOUR_RDP[j] == code_word[3:0])) begin
				ok4 = 1'b1;
				v4  = 3'(j);
			end
		end
	end

	assign res.err  = !(ok6 && ok4);
	assign res.data = (ok6 && ok4) ? {v4, v6} : 8'd0;

endmodule
